FILE: hw/rtl/dbcs_pkg.sv
// Shared types, constants and byte classification functions for the DBCS string validator.
package dbcs_pkg;

	// Kind of double-byte lead that is waiting for its trail byte.
	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_HANZI = 2'd1,
		KIND_SIGN  = 2'd2,
		KIND_KANA  = 2'd3
	} lead_kind_t;

	// One input beat as it travels between the modules.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_string;
	} text_beat_t;

	localparam logic [7:0] PRINT_LO      = 8'h20;
	localparam logic [7:0] PRINT_HI      = 8'h7e;
	localparam logic [7:0] HANZI_LEAD_LO = 8'hb0;
	localparam logic [7:0] HANZI_LEAD_HI = 8'hf7;
	localparam logic [7:0] SIGN_LEAD_A   = 8'ha1;
	localparam logic [7:0] SIGN_LEAD_B   = 8'ha3;
	localparam logic [7:0] KANA_LEAD_A   = 8'ha4;
	localparam logic [7:0] KANA_LEAD_B   = 8'ha5;
	localparam logic [7:0] TRAIL_LO      = 8'ha1;
	localparam logic [7:0] TRAIL_HI      = 8'hfe;
	localparam logic [7:0] KANA_TRAIL_HI = 8'hf3;

	// Plain printable ASCII byte.
	function automatic logic is_printable(input logic [7:0] b);
		return (b >= PRINT_LO) && (b <= PRINT_HI);
	endfunction

	// Lead kind that a byte opens, or none.
	function automatic lead_kind_t lead_kind_of(input logic [7:0] b);
		lead_kind_t k;
		k = KIND_NONE;
		if ((b >= HANZI_LEAD_LO) && (b <= HANZI_LEAD_HI))
			k = KIND_HANZI;
		else if ((b == SIGN_LEAD_A) || (b == SIGN_LEAD_B))
			k = KIND_SIGN;
		else if ((b == KANA_LEAD_A) || (b == KANA_LEAD_B))
			k = KIND_KANA;
		return k;
	endfunction

	// Whether a byte is a valid trail for the pending lead kind.
	function automatic logic trail_ok(input lead_kind_t k, input logic [7:0] b);
		logic ok;
		if (k == KIND_KANA)
			ok = (b >= TRAIL_LO) && (b <= KANA_TRAIL_HI);
		else
			ok = (b >= TRAIL_LO) && (b <= TRAIL_HI);
		return ok;
	endfunction

endpackage

FILE: hw/rtl/dbcs_text_if.sv
// Valid/ready channel that carries string bytes and the terminator mark.
interface dbcs_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_string;

	modport source (output valid, output text_byte, output end_of_string, input ready);
	modport sink   (input valid, input text_byte, input end_of_string, output ready);
endinterface

FILE: hw/rtl/dbcs_verdict_if.sv
// Valid/ready channel that carries the per-string verdict.
interface dbcs_verdict_if;
	logic valid;
	logic ready;
	logic string_bad;

	modport source (output valid, output string_bad, input ready);
	modport sink   (input valid, input string_bad, output ready);
endinterface

FILE: hw/rtl/dbcs_string_validator.sv
// Top level of the DBCS string validator: input stage, checker and verdict register.
//
// Usage: the text channel takes one string byte per beat; a beat with
// end_of_string set closes the string, and its text_byte is ignored. Each
// terminator produces exactly one beat on the verdict channel, string_bad
// set when an unknown byte or a broken double-byte pair was seen, or when
// a lead byte was left without its trail. Byte beats produce no output.
// Throughput: one beat per cycle, sustained, as long as verdicts are taken.
// A terminator passes through the input stage, then its verdict is loaded
// into the verdict register, which drives the verdict port.
// The checking state is updated as a beat leaves the input stage, so every
// byte is a single compare-and-select step within that cycle.
// Reset clears the input stage, the checking state and the verdict register;
// the block is ready for a new string right after reset is released.
// When the receiver stalls, a held verdict stays on the port; byte beats
// keep flowing, and only a second terminator waits in the input stage,
// which then backpressures the text channel until the verdict is taken.
// Bytes at or past position MAX_CHECK_LEN are not checked, except a trail
// that completes a pair begun at the last checked position.
module dbcs_string_validator
	import dbcs_pkg::*;
#(
	parameter int MAX_CHECK_LEN = 255
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dbcs_text_if.sink             text,
	dbcs_verdict_if.source        verdict
);

	logic       valid_s1;
	text_beat_t beat_s1;
	logic       advance_s1;
	logic       check_verdict;
	logic       valid_q;
	logic       bad_q;

	// A byte beat always leaves the stage; a terminator needs a free verdict slot.
	assign advance_s1 = valid_s1 &&
		(!beat_s1.end_of_string || !valid_q || verdict.ready);
	assign text.ready = !valid_s1 || advance_s1;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (text.ready)
			valid_s1 <= text.valid;
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			beat_s1.text_byte     <= text.text_byte;
			beat_s1.end_of_string <= text.end_of_string;
		end
	end

	dbcs_check #(
		.MAX_CHECK_LEN(MAX_CHECK_LEN)
	) u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance_s1),
		.beat   (beat_s1),
		.verdict(check_verdict)
	);

	// Verdict register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (advance_s1 && beat_s1.end_of_string)
			valid_q <= 1'b1;
		else if (verdict.ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && beat_s1.end_of_string)
			bad_q <= check_verdict;
	end

	assign verdict.valid      = valid_q;
	assign verdict.string_bad = bad_q;

	// A terminator never overwrites a verdict that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && beat_s1.end_of_string |-> !valid_q || verdict.ready)
		else $error("verdict overwritten");

	// Backpressure on the text channel only comes from a stalled terminator.
	assert property (@(posedge clk) disable iff (!arst_n)
		!text.ready |-> valid_s1 && beat_s1.end_of_string && valid_q && !verdict.ready)
		else $error("input stalled without cause");

	// A verdict appears only after a terminator left the input stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_q) |-> $past(advance_s1 && beat_s1.end_of_string))
		else $error("verdict without terminator");

endmodule

FILE: hw/rtl/dbcs_check.sv
// Per-string checking state: byte position, pending lead kind and sticky bad flag.
module dbcs_check
	import dbcs_pkg::*;
#(
	parameter int MAX_CHECK_LEN = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  text_beat_t beat,
	output logic       verdict
);

	localparam int PosW = $clog2(MAX_CHECK_LEN + 1);
	localparam logic [PosW-1:0] PosMax = PosW'(MAX_CHECK_LEN);

	logic [PosW-1:0] pos_q, pos_d;
	lead_kind_t      kind_q, kind_d;
	logic            bad_q, bad_d;
	logic            in_window;
	lead_kind_t      new_kind;

	assign in_window = (pos_q < PosMax);
	assign new_kind  = lead_kind_of(beat.text_byte);

	// The terminator's verdict also counts a lead left without its trail.
	assign verdict = bad_q | (kind_q != KIND_NONE);

	// Next state for one beat.
	always_comb begin
		pos_d  = pos_q;
		kind_d = kind_q;
		bad_d  = bad_q;
		if (beat.end_of_string) begin
			pos_d  = '0;
			kind_d = KIND_NONE;
			bad_d  = 1'b0;
		end else begin
			if (kind_q != KIND_NONE) begin
				if (!trail_ok(kind_q, beat.text_byte))
					bad_d = 1'b1;
				kind_d = KIND_NONE;
			end else if (in_window && !is_printable(beat.text_byte)) begin
				if (new_kind == KIND_NONE)
					bad_d = 1'b1;
				else
					kind_d = new_kind;
			end
			if (in_window)
				pos_d = pos_q + 1'b1;
		end
	end

	// State registers advance once per beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			kind_q <= KIND_NONE;
			bad_q  <= 1'b0;
		end else if (step) begin
			pos_q  <= pos_d;
			kind_q <= kind_d;
			bad_q  <= bad_d;
		end
	end

	// A terminator leaves the state cleared for the next string.
	assert property (@(posedge clk) disable iff (!arst_n)
		step && beat.end_of_string |=> (pos_q == '0) && (kind_q == KIND_NONE) && !bad_q)
		else $error("state not cleared after terminator");

	// The position saturates and never passes the check limit.
	assert property (@(posedge clk) disable iff (!arst_n) pos_q <= PosMax)
		else $error("byte position beyond limit");

	// A fault stays recorded until the terminator.
	assert property (@(posedge clk) disable iff (!arst_n)
		bad_q && !(step && beat.end_of_string) |=> bad_q)
		else $error("bad flag cleared inside a string");

endmodule

FILE: tb/dbcs_verdict_checker.sv
// Checker that predicts the string verdicts of the DBCS string validator and compares them.
`timescale 1ns / 1ps

module dbcs_verdict_checker
	import dbcs_pkg::*;
#(
	parameter int MAX_CHECK_LEN = 255
) (
	input  logic    clk,
	input  logic    arst_n,
	dbcs_text_if    text,
	dbcs_verdict_if verdict,
	output int      fail_count,
	output int      verdicts_owed
);

	// Scan state of the string being received.
	logic [8:0] scan_pos;
	lead_kind_t open_lead;
	logic       fault_seen;

	// Verdicts predicted for terminators that have not been answered yet.
	logic       owed_verdicts[$];

	int         new_fails;
	logic       want_bad;

	// Lead kind opened by a byte, none when the byte opens no pair.
	function automatic lead_kind_t lead_of(input logic [7:0] b);
		if (b == SIGN_LEAD_A || b == SIGN_LEAD_B)
			return KIND_SIGN;
		if (b == KANA_LEAD_A || b == KANA_LEAD_B)
			return KIND_KANA;
		if (b >= HANZI_LEAD_LO && b <= HANZI_LEAD_HI)
			return KIND_HANZI;
		return KIND_NONE;
	endfunction

	// Whether a byte closes a pair opened by the given lead kind.
	function automatic logic trail_fits(input lead_kind_t k, input logic [7:0] b);
		logic [7:0] top_trail;
		top_trail = (k == KIND_KANA) ? KANA_TRAIL_HI : TRAIL_HI;
		return (b >= TRAIL_LO) && (b <= top_trail);
	endfunction

	// Advance the scan state by one string byte.
	task automatic scan_byte(input logic [7:0] b);
		lead_kind_t k;
		if (open_lead != KIND_NONE) begin
			if (!trail_fits(open_lead, b))
				fault_seen = 1'b1;
			open_lead = KIND_NONE;
		end else if (scan_pos < MAX_CHECK_LEN) begin
			if (b < PRINT_LO || b > PRINT_HI) begin
				k = lead_of(b);
				if (k == KIND_NONE)
					fault_seen = 1'b1;
				else
					open_lead = k;
			end
		end
		if (scan_pos < MAX_CHECK_LEN)
			scan_pos = scan_pos + 9'd1;
	endtask

	// Watch both channels; verdicts first, since a terminator taken at this
	// edge must pass the input stage and the verdict register before it is answered.
	always @(posedge clk) begin
		if (!arst_n) begin
			scan_pos = '0;
			open_lead = KIND_NONE;
			fault_seen = 1'b0;
			owed_verdicts.delete();
			fail_count <= 0;
			verdicts_owed <= 0;
		end else begin
			new_fails = 0;
			if (verdict.valid && verdict.ready) begin
				if (owed_verdicts.size() == 0) begin
					$error("string_bad: no verdict expected, actual %0b", verdict.string_bad);
					new_fails++;
				end else begin
					want_bad = owed_verdicts.pop_front();
					if (verdict.string_bad !== want_bad) begin
						$error("string_bad: expected %0b, actual %0b",
							want_bad, verdict.string_bad);
						new_fails++;
					end
				end
			end
			if (text.valid && text.ready) begin
				if (text.end_of_string) begin
					owed_verdicts.push_back(fault_seen | (open_lead != KIND_NONE));
					scan_pos = '0;
					open_lead = KIND_NONE;
					fault_seen = 1'b0;
				end else begin
					scan_byte(text.text_byte);
				end
			end
			fail_count <= fail_count + new_fails;
			verdicts_owed <= owed_verdicts.size();
		end
	end

endmodule

FILE: tb/tb_dbcs_string_validator.sv
// Testbench top for the DBCS string validator: stimulus, receiver pacing and the verdict.
`timescale 1ns / 1ps

module tb_dbcs_string_validator;
	import dbcs_pkg::*;

	localparam int CHECK_LEN    = 255;
	localparam int TARGET_ITEMS = 1450;
	localparam int HOLD_CYCLES  = 300;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   verdicts_owed;

	int   items_sent;
	int   burst_left;
	logic [7:0] str_bytes[$];

	dbcs_text_if    text_ch();
	dbcs_verdict_if verdict_ch();

	dbcs_string_validator #(
		.MAX_CHECK_LEN(CHECK_LEN)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.verdict(verdict_ch)
	);

	dbcs_verdict_checker #(
		.MAX_CHECK_LEN(CHECK_LEN)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.text         (text_ch),
		.verdict      (verdict_ch),
		.fail_count   (fail_count),
		.verdicts_owed(verdicts_owed)
	);

	// 2 ns clock.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit, far above the slowest legal run.
	initial begin
		#400000;
		$display("** dbcs_string_validator: FAILED **");
		$finish;
	end

	// A lead and trail of a random kind; a broken pair gets a trail outside its range.
	function automatic void pick_pair(output logic [7:0] lead, output logic [7:0] trail,
		input bit broken);
		lead_kind_t k;
		k = lead_kind_t'($urandom_range(1, 3));
		case (k)
			KIND_HANZI: lead = 8'($urandom_range(HANZI_LEAD_LO, HANZI_LEAD_HI));
			KIND_SIGN:  lead = $urandom_range(1) ? SIGN_LEAD_A : SIGN_LEAD_B;
			default:    lead = $urandom_range(1) ? KANA_LEAD_A : KANA_LEAD_B;
		endcase
		if (!broken)
			trail = 8'($urandom_range(TRAIL_LO,
				(k == KIND_KANA) ? KANA_TRAIL_HI : TRAIL_HI));
		else if (k == KIND_KANA && $urandom_range(1))
			trail = 8'($urandom_range(KANA_TRAIL_HI + 1, TRAIL_HI));
		else if ($urandom_range(3) != 0)
			trail = 8'($urandom_range(0, TRAIL_LO - 1));
		else
			trail = 8'hff;
	endfunction

	// Append one character: a raw noise byte, a printable byte or a pair.
	task automatic add_unit(input int noise_pct, input int broken_pct, input int room);
		int r;
		logic [7:0] lead;
		logic [7:0] trail;
		r = $urandom_range(99);
		if (r < noise_pct) begin
			str_bytes.push_back(8'($urandom_range(255)));
		end else if (room < 2 || r < noise_pct + (100 - noise_pct) / 2) begin
			str_bytes.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
		end else begin
			pick_pair(lead, trail, $urandom_range(99) < broken_pct);
			str_bytes.push_back(lead);
			str_bytes.push_back(trail);
		end
	endtask

	// Offer one beat, with burst and gap pacing, and wait until it is taken.
	task automatic send_beat(input logic [7:0] b, input logic eos);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				text_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= b;
		text_ch.end_of_string <= eos;
		do @(posedge clk); while (!text_ch.ready);
		items_sent++;
	endtask

	// Send the built string and close it with a terminator carrying a junk byte.
	task automatic send_string();
		foreach (str_bytes[i])
			send_beat(str_bytes[i], 1'b0);
		send_beat(8'($urandom_range(255)), 1'b1);
	endtask

	// Short string, mostly well formed; some carry noise or end on a bare lead.
	task automatic send_short();
		int len;
		int noise;
		logic [7:0] lead;
		logic [7:0] trail;
		str_bytes.delete();
		len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		noise = ($urandom_range(9) < 7) ? 0 : $urandom_range(5, 40);
		while (str_bytes.size() < len)
			add_unit(noise, 8, len - str_bytes.size());
		if ($urandom_range(99) < 8) begin
			pick_pair(lead, trail, 1'b0);
			str_bytes.push_back(lead);
		end
		send_string();
	endtask

	// String that runs past the check limit, clean up to its edge, where a pair or a late lead is placed.
	task automatic send_long(input int variant);
		logic [7:0] lead;
		logic [7:0] trail;
		str_bytes.delete();
		while (str_bytes.size() < CHECK_LEN - 1)
			add_unit(0, 0, CHECK_LEN - 1 - str_bytes.size());
		case (variant)
			0: begin
				// Pair at the last checked position, trail valid.
				pick_pair(lead, trail, 1'b0);
				str_bytes.push_back(lead);
				str_bytes.push_back(trail);
			end
			1: begin
				// Pair at the last checked position, trail broken.
				pick_pair(lead, trail, 1'b1);
				str_bytes.push_back(lead);
				str_bytes.push_back(trail);
			end
			default: begin
				// A lead past the limit is unchecked, so the zero after it is too.
				pick_pair(lead, trail, 1'b0);
				str_bytes.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
				str_bytes.push_back(lead);
				str_bytes.push_back(8'h00);
			end
		endcase
		repeat ($urandom_range(0, 6))
			str_bytes.push_back(8'($urandom_range(255)));
		send_string();
	endtask

	// Receiver: a changing ready pattern, plus one long hold-off that backs up the input.
	initial begin
		int mode;
		int span_left;
		int hold_left;
		int taken;
		bit held_off;
		logic phase;
		span_left = 0;
		hold_left = 0;
		taken = 0;
		held_off = 1'b0;
		phase = 1'b0;
		mode = 0;
		verdict_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (verdict_ch.valid && verdict_ch.ready)
				taken++;
			if (!held_off && taken >= 15) begin
				held_off = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (span_left == 0) begin
				mode = $urandom_range(3);
				span_left = $urandom_range(5, 60);
			end
			span_left--;
			phase = ~phase;
			if (hold_left > 0) begin
				hold_left--;
				verdict_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: verdict_ch.ready <= 1'b1;
					1: verdict_ch.ready <= phase;
					2: verdict_ch.ready <= ($urandom_range(3) != 0);
					default: verdict_ch.ready <= ($urandom_range(3) == 0);
				endcase
			end
		end
	end

	// Reset, directed strings, random strings, drain and verdict.
	initial begin
		int string_idx;
		items_sent = 0;
		burst_left = 0;
		arst_n <= 1'b0;
		text_ch.valid <= 1'b0;
		text_ch.text_byte <= 8'h00;
		text_ch.end_of_string <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty string.
		str_bytes.delete();
		send_string();
		// Printable extremes and hanzi pairs at the ends of their ranges.
		str_bytes = '{8'h20, 8'h7e, 8'hb0, 8'ha1, 8'hf7, 8'hfe};
		send_string();
		// Sign and kana leads with the ends of their trail ranges.
		str_bytes = '{8'ha1, 8'hfe, 8'ha3, 8'ha1, 8'ha4, 8'hf3, 8'ha5, 8'ha1};
		send_string();
		// Kana trail just past its range.
		str_bytes = '{8'ha4, 8'hf4};
		send_string();
		// Lead left pending at the terminator.
		str_bytes = '{8'hb0};
		send_string();
		// Zero byte, then a good byte that cannot clear the fault.
		str_bytes = '{8'h00, 8'h41};
		send_string();
		// Byte just above the hanzi lead range.
		str_bytes = '{8'hf8};
		send_string();

		string_idx = 0;
		while (items_sent < TARGET_ITEMS) begin
			if (string_idx == 20 || string_idx == 40 || string_idx == 60)
				send_long(string_idx / 20 - 1);
			else
				send_short();
			string_idx++;
		end
		text_ch.valid <= 1'b0;

		// Let the checker count the last terminator before draining.
		@(posedge clk);
		while (verdicts_owed != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("** dbcs_string_validator: PASSED **");
		else
			$display("** dbcs_string_validator: FAILED **");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/dbcs_pkg.sv
hw/rtl/dbcs_text_if.sv
hw/rtl/dbcs_verdict_if.sv
hw/rtl/dbcs_check.sv
hw/rtl/dbcs_string_validator.sv
tb/dbcs_verdict_checker.sv
tb/tb_dbcs_string_validator.sv
